// ----- rtl/core/rcmix_pkg.sv -----
`timescale 1ns / 1ps

package rcmix_pkg;

	typedef enum logic [2:0] {
		REG_OP_MODE        = 3'd0,
		REG_STICK_CENTER   = 3'd1,
		REG_NEUTRAL_BAND   = 3'd2,
		REG_DRIVE_GAIN     = 3'd3,
		REG_WINCH_LOW      = 3'd4,
		REG_WINCH_HIGH     = 3'd5,
		REG_WINCH_DAC      = 3'd6,
		REG_TIMEOUT_TICKS  = 3'd7
	} rcmix_reg_t;

	localparam logic [1:0] MODE_WINCH = 2'd1;
	localparam logic [1:0] MODE_LEFT  = 2'd2;
	localparam logic [1:0] MODE_RIGHT = 2'd3;

	localparam logic ITEM_FRAME = 1'b0;
	localparam logic ITEM_TICK  = 1'b1;

	localparam int CFG_DATA_BITS = 16;
	localparam int REG_INDEX_BITS = 3;

	localparam logic [11:0] DAC_NEUTRAL = 12'd2047;
	localparam logic [11:0] DAC_OFFSET  = 12'd2048;
	localparam logic [11:0] DAC_MAX     = 12'd4095;
	localparam logic [15:0] WINCH_FAILSAFE_VALUE = 16'd1000;

	localparam logic [1:0]  RST_OP_MODE      = MODE_LEFT;
	localparam logic [7:0]  RST_NEUTRAL_BAND = 8'd10;
	localparam logic [3:0]  RST_DRIVE_GAIN   = 4'd5;
	localparam logic [11:0] RST_WINCH_DAC    = 12'd2730;
	localparam logic [15:0] RST_TIMEOUT      = 16'd500;
	localparam int RST_STICK_CENTER = 992;
	localparam int RST_WINCH_LOW    = 500;
	localparam int RST_WINCH_HIGH   = 1500;

	typedef struct packed {
		logic [11:0] dac_value;
		logic        reverse_drive;
		logic        forward_drive;
		logic        from_failsafe;
	} rcmix_result_t;

endpackage

// ----- rtl/core/rcmix_datapath.sv -----
`timescale 1ns / 1ps

module rcmix_datapath #(
	parameter int CHANNEL_BITS = 11
) (
	input  logic                               is_tick,
	input  logic [CHANNEL_BITS-1:0]            channel_one,
	input  logic [CHANNEL_BITS-1:0]            channel_two,
	input  logic [CHANNEL_BITS-1:0]            channel_twelve,
	input  logic [1:0]                         op_mode,
	input  logic [CHANNEL_BITS-1:0]            stick_center,
	input  logic [7:0]                         neutral_band,
	input  logic [3:0]                         drive_gain,
	input  logic [CHANNEL_BITS-1:0]            winch_low_threshold,
	input  logic [CHANNEL_BITS-1:0]            winch_high_threshold,
	input  logic [11:0]                        winch_dac_level,
	input  logic [15:0]                        timeout_ticks,
	input  logic signed [CHANNEL_BITS+1:0]     prev_mix,
	input  logic [15:0]                        ticks,
	output logic                               has_result,
	output rcmix_pkg::rcmix_result_t           result,
	output logic                               mix_load,
	output logic signed [CHANNEL_BITS+1:0]     mix_next,
	output logic [15:0]                        ticks_next
);
	import rcmix_pkg::*;

	localparam int MW = CHANNEL_BITS + 2;
	localparam int AW = MW + 1;
	localparam int PW = MW + 5;
	localparam int LW = PW + 1;

	logic [16:0]           tick_inc;
	logic                  timed_out;
	logic                  winch;
	logic [15:0]           winch_value;
	logic [15:0]           low_w;
	logic [15:0]           high_w;
	logic signed [MW-1:0]  x_c;
	logic signed [MW-1:0]  y_c;
	logic signed [MW-1:0]  mix;
	logic signed [MW:0]    sum;
	logic signed [MW:0]    half;
	logic signed [MW-1:0]  avg;
	logic signed [AW-1:0]  avg_w;
	logic signed [AW-1:0]  band_w;
	logic                  in_band;
	logic signed [PW-1:0]  avg_p;
	logic signed [PW-1:0]  gain_p;
	logic signed [PW-1:0]  prod;
	logic signed [LW-1:0]  level;
	logic [11:0]           track_dac;

	assign tick_inc  = {1'b0, ticks} + 17'd1;
	assign timed_out = tick_inc > {1'b0, timeout_ticks};
	assign winch     = (op_mode == MODE_WINCH);

	assign winch_value = is_tick ? WINCH_FAILSAFE_VALUE : 16'(channel_twelve);
	assign low_w       = 16'(winch_low_threshold);
	assign high_w      = 16'(winch_high_threshold);

	assign x_c = signed'(MW'(channel_one)) - signed'(MW'(stick_center));
	assign y_c = signed'(MW'(channel_two)) - signed'(MW'(stick_center));

	always_comb begin
		if (is_tick) begin
			mix = '0;
		end else if (op_mode == MODE_RIGHT) begin
			mix = y_c - x_c;
		end else begin
			mix = x_c + y_c;
		end
	end

	// halve toward zero
	assign sum  = AW'(mix) + AW'(prev_mix);
	assign half = (sum + signed'(AW'(sum[MW]))) >>> 1;
	assign avg  = half[MW-1:0];

	assign avg_w   = AW'(avg);
	assign band_w  = signed'(AW'(neutral_band));
	assign in_band = (avg_w < band_w) && (avg_w > -band_w);

	assign avg_p  = PW'(avg);
	assign gain_p = signed'(PW'(drive_gain));
	assign prod   = avg_p * gain_p;
	assign level  = LW'(prod) + signed'(LW'(DAC_OFFSET));

	always_comb begin
		if (in_band) begin
			track_dac = DAC_NEUTRAL;
		end else if (level < 0) begin
			track_dac = '0;
		end else if (level > signed'(LW'(DAC_MAX))) begin
			track_dac = DAC_MAX;
		end else begin
			track_dac = level[11:0];
		end
	end

	always_comb begin
		has_result = !is_tick || timed_out;
		mix_load   = has_result && !winch;
		mix_next   = mix;
		if (is_tick && !timed_out) begin
			ticks_next = tick_inc[15:0];
		end else begin
			ticks_next = '0;
		end
		result.from_failsafe = is_tick;
		if (winch) begin
			result.dac_value     = winch_dac_level;
			result.reverse_drive = winch_value < low_w;
			result.forward_drive = (winch_value >= low_w) && (winch_value > high_w);
		end else begin
			result.dac_value     = track_dac;
			result.reverse_drive = 1'b0;
			result.forward_drive = 1'b0;
		end
	end

endmodule

// ----- rtl/core/rc_channel_motor_mixer_unit.sv -----
`timescale 1ns / 1ps

// Motor mixer for decoded radio-control frames.
// Slave side: one beat is either a channel frame (s_tuser = 0) carrying
// channels one, two and twelve, or a one-millisecond tick (s_tuser = 1).
// Master side: one beat per frame and one per link timeout; a plain tick
// gives nothing. m_tuser flags a failsafe result.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
// while no beat is in flight.
// A beat taken from the slave side is held in the stage register, and its
// result is then loaded into the output register. Throughput is one beat per
// clock while the master does not stall; the filter state and the tick
// counter are updated by the single stage between the two registers.
// Reset clears both registers' valid flags, the mix history and the tick
// count, and loads the default configuration.
// A stalled master holds the output register; the stage register then holds
// a beat that has a result, and s_tready drops. A tick without a result
// still drains from the stage while the master stalls.
module rc_channel_motor_mixer_unit #(
	parameter int CHANNEL_BITS = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// channel_one, channel_two, channel_twelve, zero fill
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
	// item kind: channel frame (0) or tick (1)
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// dac_value, reverse_drive, forward_drive, zero fill
	output logic [15:0]                         m_tdata,
	// from_failsafe
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [rcmix_pkg::REG_INDEX_BITS-1:0] cfg_index,
	input  logic [rcmix_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import rcmix_pkg::*;

	localparam int CB = CHANNEL_BITS;
	localparam int MW = CB + 2;

	logic [1:0]           op_mode_q;
	logic [CB-1:0]        stick_center_q;
	logic [7:0]           neutral_band_q;
	logic [3:0]           drive_gain_q;
	logic [CB-1:0]        winch_low_q;
	logic [CB-1:0]        winch_high_q;
	logic [11:0]          winch_dac_q;
	logic [15:0]          timeout_q;

	logic                 valid_s1;
	logic                 tick_s1;
	logic [CB-1:0]        ch_one_s1;
	logic [CB-1:0]        ch_two_s1;
	logic [CB-1:0]        ch_twelve_s1;

	logic signed [MW-1:0] prev_mix_q;
	logic [15:0]          ticks_q;

	logic                 out_valid_q;
	rcmix_result_t        out_q;

	logic                 has_result;
	rcmix_result_t        result;
	logic                 mix_load;
	logic signed [MW-1:0] mix_next;
	logic [15:0]          ticks_next;
	logic                 out_free;
	logic                 advance;
	logic                 accept;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!has_result || out_free);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q      <= RST_OP_MODE;
			stick_center_q <= CB'(RST_STICK_CENTER);
			neutral_band_q <= RST_NEUTRAL_BAND;
			drive_gain_q   <= RST_DRIVE_GAIN;
			winch_low_q    <= CB'(RST_WINCH_LOW);
			winch_high_q   <= CB'(RST_WINCH_HIGH);
			winch_dac_q    <= RST_WINCH_DAC;
			timeout_q      <= RST_TIMEOUT;
		end else if (cfg_we) begin
			unique case (rcmix_reg_t'(cfg_index))
				REG_OP_MODE:       op_mode_q      <= cfg_data[1:0];
				REG_STICK_CENTER:  stick_center_q <= cfg_data[CB-1:0];
				REG_NEUTRAL_BAND:  neutral_band_q <= cfg_data[7:0];
				REG_DRIVE_GAIN:    drive_gain_q   <= cfg_data[3:0];
				REG_WINCH_LOW:     winch_low_q    <= cfg_data[CB-1:0];
				REG_WINCH_HIGH:    winch_high_q   <= cfg_data[CB-1:0];
				REG_WINCH_DAC:     winch_dac_q    <= cfg_data[11:0];
				REG_TIMEOUT_TICKS: timeout_q      <= cfg_data[15:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1      <= s_tuser;
			ch_one_s1    <= s_tdata[CB-1:0];
			ch_two_s1    <= s_tdata[2*CB-1:CB];
			ch_twelve_s1 <= s_tdata[3*CB-1:2*CB];
		end
	end

	rcmix_datapath #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_datapath (
		.is_tick              (tick_s1 == ITEM_TICK),
		.channel_one          (ch_one_s1),
		.channel_two          (ch_two_s1),
		.channel_twelve       (ch_twelve_s1),
		.op_mode              (op_mode_q),
		.stick_center         (stick_center_q),
		.neutral_band         (neutral_band_q),
		.drive_gain           (drive_gain_q),
		.winch_low_threshold  (winch_low_q),
		.winch_high_threshold (winch_high_q),
		.winch_dac_level      (winch_dac_q),
		.timeout_ticks        (timeout_q),
		.prev_mix             (prev_mix_q),
		.ticks                (ticks_q),
		.has_result           (has_result),
		.result               (result),
		.mix_load             (mix_load),
		.mix_next             (mix_next),
		.ticks_next           (ticks_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mix_q <= '0;
			ticks_q    <= '0;
		end else if (advance) begin
			ticks_q <= ticks_next;
			if (mix_load) begin
				prev_mix_q <= mix_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.forward_drive, out_q.reverse_drive, out_q.dac_value};
	assign m_tuser  = out_q.from_failsafe;

	a_pins_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[12] && m_tdata[13]))
		else $error("reverse and forward pins both driven");

	a_track_pins_low: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && op_mode_q != MODE_WINCH) |-> (!m_tdata[12] && !m_tdata[13]))
		else $error("direction pin driven in track mode");

	a_count_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_result) |=> (ticks_q == '0))
		else $error("tick count not restarted after a result");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(tick_s1) && $stable(ch_twelve_s1)))
		else $error("stalled stage beat lost");

endmodule
